// ===== rtl/mdds_pkg.sv =====
// Shared constants, types and character codes for the multichannel DDS step generator.
package mdds_pkg;

    localparam int CHANNELS   = 5;
    localparam int PHASE_BITS = 32;
    localparam int LINE_BYTES = 64;
    localparam int FREQ_BITS  = 16;
    localparam int LEN_BITS   = $clog2(LINE_BYTES);
    localparam int FNUM_BITS  = $clog2(CHANNELS + 1);

    localparam logic [LEN_BITS-1:0] LINE_MAX = LEN_BITS'(LINE_BYTES - 1);

    typedef logic [CHANNELS-1:0]   t_chan_vec;
    typedef logic [PHASE_BITS-1:0] t_phase;
    typedef logic [FREQ_BITS-1:0]  t_freq;

    // increment = freq * 2^32 / 100000 = freq * 42949 + floor(freq * 2103 / 3125)
    localparam logic [15:0] INC_WHOLE    = 16'd42949;
    localparam logic [11:0] INC_FRAC_NUM = 12'd2103;
    localparam int          FRAC_BITS    = 28;
    localparam logic [28:0] INC_RECIP    = 29'd351843721;
    localparam int          INC_SHIFT    = 40;

    localparam t_freq LO_LIMIT_RST = 16'd100;
    localparam t_freq HI_LIMIT_RST = 16'd4000;

    localparam logic CFG_LO_LIMIT = 1'b0;
    localparam logic CFG_HI_LIMIT = 1'b1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_FREQ  = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [1:0] FP_BEFORE = 2'd0;
    localparam logic [1:0] FP_DIGITS = 2'd1;
    localparam logic [1:0] FP_DONE   = 2'd2;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_VT    = 8'h0B;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_F     = 8'h46;
    localparam logic [7:0] CHR_S     = 8'h53;

endpackage

// ===== rtl/mdds_incr_lane.sv =====
// Two-stage constant divider that turns one channel frequency into its phase increment.
module mdds_incr_lane
    import mdds_pkg::*;
(
    input  logic   i_clk,
    input  t_freq  i_freq,
    output t_phase o_incr
);

    logic [FRAC_BITS-1:0]             r_frac;
    logic [PHASE_BITS-1:0]            r_whole;
    logic [FRAC_BITS+28:0]            w_prod;
    t_phase                           r_incr;

    assign w_prod = {29'd0, r_frac} * {28'd0, INC_RECIP};

    always_ff @(posedge i_clk) begin
        r_frac  <= FRAC_BITS'(i_freq) * FRAC_BITS'(INC_FRAC_NUM);
        r_whole <= PHASE_BITS'(i_freq) * PHASE_BITS'(INC_WHOLE);
        r_incr  <= r_whole + PHASE_BITS'(w_prod >> INC_SHIFT);
    end

    assign o_incr = r_incr;

endmodule

// ===== rtl/multichannel_dds_step_generator.sv =====
// Multichannel DDS step generator: command line parser, phase accumulators and step pins.
// An accepted transaction is held in an input register; its result is held in an output register.
// Throughput: one transaction per cycle unless the output is stalled; a newline is held
// after a preceding byte while the per-channel increment dividers settle.
// Reset (synchronous, active low): all channels rest, phases and pins zero, line state
// cleared, lower limit 100 Hz, upper limit 4000 Hz.
module multichannel_dds_step_generator
    import mdds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  t_freq      i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_operation,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_chan_vec  o_step_levels,
    output t_chan_vec  o_active_channels
);

    localparam logic [1:0] STALE_CYCLES = 2'd2;

    t_freq  r_lo_limit, r_hi_limit;

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    logic       r_out_valid;
    t_chan_vec  r_out_levels, r_out_active;

    t_phase     r_inc [CHANNELS];
    t_phase     n_inc [CHANNELS];
    t_phase     r_acc [CHANNELS];
    t_phase     n_acc [CHANNELS];
    t_freq      r_store [CHANNELS];
    t_freq      n_store [CHANNELS];
    t_phase     w_cand [CHANNELS];
    t_chan_vec  r_pins, n_pins;
    t_chan_vec  n_active, w_active;

    logic [LEN_BITS-1:0]  r_len, n_len;
    logic [1:0]           r_kind, n_kind;
    logic                 r_ended, n_ended;
    logic [FNUM_BITS-1:0] r_fnum, n_fnum;
    logic [1:0]           r_fphase, n_fphase;
    logic                 r_neg, n_neg;
    t_freq                r_fvalue, n_fvalue;
    logic [1:0]           r_stale, n_stale;

    logic       w_newline, w_proc;
    logic       w_blank, w_digit, w_store_nz;
    logic       w_do_store;
    t_freq      w_digit_val, w_times10, w_signed, w_ch_freq;
    logic       w_in_range;

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_lane
            mdds_incr_lane u_lane (
                .i_clk  (i_clk),
                .i_freq (r_store[g]),
                .o_incr (w_cand[g])
            );
        end
    endgenerate

    assign w_newline  = (r_in_op == OP_BYTE) && (r_in_byte == CHR_NL);
    assign w_proc     = r_in_valid && (!r_out_valid || i_out_ready)
                        && !(w_newline && (r_stale != 2'd0));
    assign o_in_ready = !r_in_valid || w_proc;

    assign w_blank = (r_in_byte == CHR_SPACE) || (r_in_byte == CHR_TAB)
                     || (r_in_byte == CHR_VT) || (r_in_byte == CHR_FF)
                     || (r_in_byte == CHR_CR);
    assign w_digit     = (r_in_byte >= CHR_ZERO) && (r_in_byte <= CHR_NINE);
    assign w_digit_val = {12'd0, r_in_byte[3:0]};
    assign w_times10   = (r_fvalue << 3) + (r_fvalue << 1) + w_digit_val;

    always_comb begin
        w_active   = '0;
        n_active   = '0;
        w_store_nz = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            w_active[i] = (r_inc[i] != '0);
            n_active[i] = (n_inc[i] != '0);
            w_store_nz  = w_store_nz | (r_store[i] != '0);
        end
    end

    always_comb begin
        n_inc      = r_inc;
        n_acc      = r_acc;
        n_store    = r_store;
        n_pins     = r_pins;
        n_len      = r_len;
        n_kind     = r_kind;
        n_ended    = r_ended;
        n_fnum     = r_fnum;
        n_fphase   = r_fphase;
        n_neg      = r_neg;
        n_fvalue   = r_fvalue;
        w_do_store = 1'b0;
        w_signed   = '0;
        w_ch_freq  = '0;
        w_in_range = 1'b0;
        n_stale    = (r_stale != 2'd0) ? r_stale - 2'd1 : 2'd0;

        if (w_proc) begin
            if (r_in_op == OP_TICK) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    n_acc[i]  = r_acc[i] + r_inc[i];
                    n_pins[i] = n_acc[i][PHASE_BITS-1];
                end
            end else if (w_newline) begin
                if ((r_len != '0) && ((r_kind == KIND_STOP) || (r_kind == KIND_FREQ))) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        w_ch_freq  = (r_kind == KIND_FREQ) ? r_store[i] : '0;
                        w_in_range = (w_ch_freq >= r_lo_limit) && (w_ch_freq <= r_hi_limit);
                        if (!w_in_range) begin
                            n_inc[i]  = '0;
                            n_acc[i]  = '0;
                            n_pins[i] = 1'b0;
                        end else begin
                            n_inc[i] = (r_kind == KIND_FREQ) ? w_cand[i] : '0;
                        end
                    end
                end
                n_len    = '0;
                n_kind   = KIND_NONE;
                n_ended  = 1'b0;
                n_fnum   = '0;
                n_fphase = FP_BEFORE;
                n_neg    = 1'b0;
                n_fvalue = '0;
                for (int i = 0; i < CHANNELS; i++) begin
                    n_store[i] = '0;
                end
                n_stale = STALE_CYCLES;
            end else begin
                n_stale = STALE_CYCLES;
                if (r_len != LINE_MAX) begin
                    n_len = r_len + LEN_BITS'(1);
                    if (!r_ended) begin
                        priority if (r_in_byte == CHR_NUL) begin
                            n_ended = 1'b1;
                        end else if (r_len == '0) begin
                            n_kind = (r_in_byte == CHR_S) ? KIND_STOP :
                                     (r_in_byte == CHR_F) ? KIND_FREQ : KIND_OTHER;
                        end else if (r_kind == KIND_FREQ) begin
                            if (r_in_byte == CHR_COMMA) begin
                                if (r_fnum < FNUM_BITS'(CHANNELS)) begin
                                    n_fnum = r_fnum + FNUM_BITS'(1);
                                end
                                n_fphase = FP_BEFORE;
                                n_neg    = 1'b0;
                                n_fvalue = '0;
                            end else begin
                                w_do_store = 1'b1;
                                unique case (r_fphase)
                                    FP_BEFORE: begin
                                        priority if (w_blank) begin
                                            w_do_store = 1'b0;
                                        end else if ((r_in_byte == CHR_PLUS)
                                                     || (r_in_byte == CHR_MINUS)) begin
                                            n_neg    = (r_in_byte == CHR_MINUS);
                                            n_fphase = FP_DIGITS;
                                        end else if (w_digit) begin
                                            n_fvalue = w_digit_val;
                                            n_fphase = FP_DIGITS;
                                        end else begin
                                            n_fphase = FP_DONE;
                                        end
                                    end
                                    FP_DIGITS: begin
                                        if (w_digit) begin
                                            n_fvalue = w_times10;
                                        end else begin
                                            n_fphase = FP_DONE;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                                w_signed = n_neg ? t_freq'(0) - n_fvalue : n_fvalue;
                                for (int i = 0; i < CHANNELS; i++) begin
                                    if (w_do_store && (r_fnum == FNUM_BITS'(i))) begin
                                        n_store[i] = w_signed;
                                    end
                                end
                            end
                        end else begin
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_limit <= LO_LIMIT_RST;
            r_hi_limit <= HI_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LO_LIMIT: r_lo_limit <= i_cfg_data;
                CFG_HI_LIMIT: r_hi_limit <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pins      <= '0;
            r_len       <= '0;
            r_kind      <= KIND_NONE;
            r_ended     <= 1'b0;
            r_fnum      <= '0;
            r_fphase    <= FP_BEFORE;
            r_neg       <= 1'b0;
            r_fvalue    <= '0;
            r_stale     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_inc[i]   <= '0;
                r_acc[i]   <= '0;
                r_store[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_inc    <= n_inc;
            r_acc    <= n_acc;
            r_store  <= n_store;
            r_pins   <= n_pins;
            r_len    <= n_len;
            r_kind   <= n_kind;
            r_ended  <= n_ended;
            r_fnum   <= n_fnum;
            r_fphase <= n_fphase;
            r_neg    <= n_neg;
            r_fvalue <= n_fvalue;
            r_stale  <= n_stale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op   <= i_operation;
            r_in_byte <= i_rx_byte;
        end
        if (w_proc) begin
            r_out_levels <= n_pins;
            r_out_active <= n_active;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_step_levels     = r_out_levels;
    assign o_active_channels = r_out_active;

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_levels == r_pins) && (r_out_active == w_active))
        else $error("pending result differs from channel state");

    a_field_number_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fnum <= FNUM_BITS'(CHANNELS))
        else $error("field number beyond channel count");

    a_fields_clear_off_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind != KIND_FREQ) |-> (!w_store_nz && (r_fnum == '0)))
        else $error("field state set outside a frequency line");

    a_held_transaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_proc) |=> (r_in_valid && $stable(r_in_op) && $stable(r_in_byte)))
        else $error("waiting transaction lost or changed");

endmodule
